// ===== hdl/hpq_pkg.sv =====
// Package for the binary min-heap queue: control word layout, status codes
// and the microprogram held as a constant read-only table.
// No dependencies; every other file of the block depends on it.
package hpq_pkg;

  // Fixed payload widths of the two channels.
  localparam int unsigned KEY_IN_W = 32;
  localparam int unsigned KEY_OUT_W = 32;
  localparam int unsigned OCC_W = 11;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_REMOVED  = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FULL     = 2'd3
  } hpq_status_t;

  // Microprogram step addresses.
  typedef enum logic [4:0] {
    U_IDLE   = 5'd0,
    U_DISP   = 5'd1,
    U_ICHK   = 5'd2,
    U_I0     = 5'd3,
    U_I1     = 5'd4,
    U_I2     = 5'd5,
    U_I3     = 5'd6,
    U_IPLACE = 5'd7,
    U_R0     = 5'd8,
    U_R1     = 5'd9,
    U_R2     = 5'd10,
    U_R3     = 5'd11,
    U_D0     = 5'd12,
    U_D1     = 5'd13,
    U_D2     = 5'd14,
    U_D3     = 5'd15,
    U_D4     = 5'd16,
    U_DPLACE = 5'd17,
    U_EMPTY  = 5'd18,
    U_FULL   = 5'd19,
    U_FIN    = 5'd20
  } hpq_upc_t;

  // How the step counter moves on.
  typedef enum logic [1:0] {
    JK_NEXT   = 2'd0,  // go to the following step
    JK_BRANCH = 2'd1,  // condition true: go to target, else following step
    JK_HOLD   = 2'd2   // condition true: stay, else go to target
  } hpq_jump_t;

  // Conditions tested by a jump.
  typedef enum logic [3:0] {
    COND_TRUE         = 4'd0,
    COND_NO_IN        = 4'd1,
    COND_REMOVE       = 4'd2,
    COND_FULL         = 4'd3,
    COND_EMPTY        = 4'd4,
    COND_POS_ZERO     = 4'd5,
    COND_PAR_NOT_LT   = 4'd6,
    COND_NO_LEFT      = 4'd7,
    COND_CHILD_NOT_LT = 4'd8,
    COND_OUT_BUSY     = 4'd9
  } hpq_cond_t;

  // Memory read address selection.
  typedef enum logic [2:0] {
    RD_NONE   = 3'd0,
    RD_ROOT   = 3'd1,
    RD_PARENT = 3'd2,
    RD_LEFT   = 3'd3,
    RD_RIGHT  = 3'd4,
    RD_LAST   = 3'd5
  } hpq_rd_t;

  // Memory write data selection; the address is always the hole position.
  typedef enum logic [1:0] {
    WR_NONE = 2'd0,
    WR_HKEY = 2'd1,
    WR_RDAT = 2'd2,
    WR_CKEY = 2'd3
  } hpq_wr_t;

  typedef enum logic [2:0] {
    POS_HOLD   = 3'd0,
    POS_CNT    = 3'd1,
    POS_PARENT = 3'd2,
    POS_CIDX   = 3'd3,
    POS_ZERO   = 3'd4
  } hpq_pos_t;

  typedef enum logic [1:0] {
    CNT_HOLD = 2'd0,
    CNT_INC  = 2'd1,
    CNT_DEC  = 2'd2
  } hpq_cnt_t;

  typedef enum logic [1:0] {
    KO_HOLD  = 2'd0,
    KO_CLEAR = 2'd1,
    KO_RDAT  = 2'd2
  } hpq_ko_t;

  typedef enum logic [1:0] {
    CH_HOLD  = 2'd0,
    CH_LEFT  = 2'd1,
    CH_RIGHT = 2'd2
  } hpq_ch_t;

  // One control word of the microprogram.
  typedef struct packed {
    hpq_jump_t   jk;
    hpq_cond_t   cond;
    hpq_upc_t    tgt;
    hpq_rd_t     rd;
    hpq_wr_t     wr;
    hpq_pos_t    pos;
    logic        hk_rdat;  // moving key takes the memory read data
    hpq_cnt_t    cnt;
    hpq_ko_t     ko;
    hpq_ch_t     ch;
    logic        st_ld;
    hpq_status_t st;
    logic        in_ld;    // capture an input beat
    logic        out_ld;   // hand the result to the output register
  } hpq_uword_t;

  // Status flags from the datapath to the sequencer.
  typedef struct packed {
    logic remove;
    logic full;
    logic empty;
    logic pos_zero;
    logic par_not_lt;
    logic no_left;
    logic child_not_lt;
    logic out_busy;
  } hpq_flags_t;

  localparam hpq_uword_t UW_NOP = '{
    jk: JK_NEXT, cond: COND_TRUE, tgt: U_IDLE, rd: RD_NONE, wr: WR_NONE,
    pos: POS_HOLD, hk_rdat: 1'b0, cnt: CNT_HOLD, ko: KO_HOLD, ch: CH_HOLD,
    st_ld: 1'b0, st: ST_INSERTED, in_ld: 1'b0, out_ld: 1'b0
  };

  // The microprogram. Insert keeps the new key in a register and moves
  // larger parents down into the hole; remove does the same downwards.
  function automatic hpq_uword_t hpq_urom(hpq_upc_t a);
    hpq_uword_t w;
    w = UW_NOP;
    case (a)
      U_IDLE: begin
        w.jk = JK_HOLD; w.cond = COND_NO_IN; w.tgt = U_DISP; w.in_ld = 1'b1;
      end
      U_DISP: begin
        w.jk = JK_BRANCH; w.cond = COND_REMOVE; w.tgt = U_R0;
      end
      U_ICHK: begin
        w.jk = JK_BRANCH; w.cond = COND_FULL; w.tgt = U_FULL;
      end
      U_I0: begin
        w.pos = POS_CNT; w.cnt = CNT_INC; w.ko = KO_CLEAR;
        w.st_ld = 1'b1; w.st = ST_INSERTED;
      end
      U_I1: begin
        w.jk = JK_BRANCH; w.cond = COND_POS_ZERO; w.tgt = U_IPLACE;
        w.rd = RD_PARENT;
      end
      U_I2: begin
        w.jk = JK_BRANCH; w.cond = COND_PAR_NOT_LT; w.tgt = U_IPLACE;
      end
      U_I3: begin
        w.jk = JK_BRANCH; w.cond = COND_TRUE; w.tgt = U_I1;
        w.wr = WR_RDAT; w.pos = POS_PARENT;
      end
      U_IPLACE: begin
        w.jk = JK_BRANCH; w.cond = COND_TRUE; w.tgt = U_FIN; w.wr = WR_HKEY;
      end
      U_R0: begin
        w.jk = JK_BRANCH; w.cond = COND_EMPTY; w.tgt = U_EMPTY; w.rd = RD_ROOT;
      end
      U_R1: begin
        w.ko = KO_RDAT; w.cnt = CNT_DEC; w.st_ld = 1'b1; w.st = ST_REMOVED;
      end
      U_R2: begin
        w.jk = JK_BRANCH; w.cond = COND_EMPTY; w.tgt = U_FIN;
        w.rd = RD_LAST; w.pos = POS_ZERO;
      end
      U_R3: begin
        w.hk_rdat = 1'b1;
      end
      U_D0: begin
        w.jk = JK_BRANCH; w.cond = COND_NO_LEFT; w.tgt = U_DPLACE;
        w.rd = RD_LEFT;
      end
      U_D1: begin
        w.ch = CH_LEFT; w.rd = RD_RIGHT;
      end
      U_D2: begin
        w.ch = CH_RIGHT;
      end
      U_D3: begin
        w.jk = JK_BRANCH; w.cond = COND_CHILD_NOT_LT; w.tgt = U_DPLACE;
      end
      U_D4: begin
        w.jk = JK_BRANCH; w.cond = COND_TRUE; w.tgt = U_D0;
        w.wr = WR_CKEY; w.pos = POS_CIDX;
      end
      U_DPLACE: begin
        w.jk = JK_BRANCH; w.cond = COND_TRUE; w.tgt = U_FIN; w.wr = WR_HKEY;
      end
      U_EMPTY: begin
        w.jk = JK_BRANCH; w.cond = COND_TRUE; w.tgt = U_FIN;
        w.ko = KO_CLEAR; w.st_ld = 1'b1; w.st = ST_EMPTY;
      end
      U_FULL: begin
        w.jk = JK_BRANCH; w.cond = COND_TRUE; w.tgt = U_FIN;
        w.ko = KO_CLEAR; w.st_ld = 1'b1; w.st = ST_FULL;
      end
      U_FIN: begin
        w.jk = JK_HOLD; w.cond = COND_OUT_BUSY; w.tgt = U_IDLE; w.out_ld = 1'b1;
      end
      default: begin
        w.jk = JK_BRANCH; w.cond = COND_TRUE; w.tgt = U_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

// ===== hdl/hpq_chan_if.sv =====
// Valid/ready channel interfaces for the heap queue: request and result.
// Depends on hpq_pkg for the payload widths.
interface hpq_in_if;
  logic                         valid;
  logic                         ready;
  logic                         mode;
  logic [hpq_pkg::KEY_IN_W-1:0] key;

  modport source (output valid, output mode, output key, input ready);
  modport sink (input valid, input mode, input key, output ready);
endinterface

interface hpq_out_if;
  logic                          valid;
  logic                          ready;
  logic [hpq_pkg::KEY_OUT_W-1:0] key_out;
  logic [1:0]                    status;
  logic [hpq_pkg::OCC_W-1:0]     occupancy;

  modport source (output valid, output key_out, output status, output occupancy,
                  input ready);
  modport sink (input valid, input key_out, input status, input occupancy,
                output ready);
endinterface

// ===== hdl/hpq_seq.sv =====
// Microprogram sequencer: step counter, control word table and jump logic.
// Depends on hpq_pkg for the control word, conditions and the table itself.
module hpq_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  hpq_pkg::hpq_flags_t flags,
  output hpq_pkg::hpq_uword_t uw,
  output logic                in_ready
);
  import hpq_pkg::*;

  hpq_upc_t upc_r;
  hpq_upc_t upc_nxt;
  hpq_upc_t upc_inc;
  logic     hit;

  // Fetch the control word of the current step.
  assign uw = hpq_urom(upc_r);

  // Input beats are only taken in the idle step.
  assign in_ready = (upc_r == U_IDLE);

  // Evaluate the selected condition.
  always_comb begin
    case (uw.cond)
      COND_TRUE:         hit = 1'b1;
      COND_NO_IN:        hit = ~in_valid;
      COND_REMOVE:       hit = flags.remove;
      COND_FULL:         hit = flags.full;
      COND_EMPTY:        hit = flags.empty;
      COND_POS_ZERO:     hit = flags.pos_zero;
      COND_PAR_NOT_LT:   hit = flags.par_not_lt;
      COND_NO_LEFT:      hit = flags.no_left;
      COND_CHILD_NOT_LT: hit = flags.child_not_lt;
      COND_OUT_BUSY:     hit = flags.out_busy;
      default:           hit = 1'b0;
    endcase
  end

  // Choose the next step.
  always_comb begin
    upc_inc = hpq_upc_t'(upc_r + 5'd1);
    case (uw.jk)
      JK_NEXT:   upc_nxt = upc_inc;
      JK_BRANCH: upc_nxt = hit ? uw.tgt : upc_inc;
      JK_HOLD:   upc_nxt = hit ? upc_r : uw.tgt;
      default:   upc_nxt = U_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= U_IDLE;
    end else begin
      upc_r <= upc_nxt;
    end
  end

endmodule

// ===== hdl/hpq_dpath.sv =====
// Heap datapath: key memory, hole position, moving and child key registers,
// entry count and the output register. Depends on hpq_pkg.
module hpq_dpath #(
  parameter int unsigned CAPACITY  = 1024,
  parameter int unsigned KEY_WIDTH = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  hpq_pkg::hpq_uword_t              uw,
  output hpq_pkg::hpq_flags_t              flags,
  input  logic                             in_valid,
  input  logic                             in_mode,
  input  logic [hpq_pkg::KEY_IN_W-1:0]     in_key,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [hpq_pkg::KEY_OUT_W-1:0]    out_key_out,
  output logic [1:0]                       out_status,
  output logic [hpq_pkg::OCC_W-1:0]        out_occupancy
);
  import hpq_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned IW = AW + 2;

  logic [KEY_WIDTH-1:0] mem [CAPACITY];

  logic                 mode_r;
  logic [KEY_WIDTH-1:0] hkey_r;
  logic [KEY_WIDTH-1:0] ckey_r;
  logic [KEY_WIDTH-1:0] rdat_r;
  logic [KEY_WIDTH-1:0] kout_r;
  logic [AW-1:0]        pos_r;
  logic [AW-1:0]        cidx_r;
  logic [CW-1:0]        cnt_r;
  hpq_status_t          st_r;

  logic                 out_valid_r;
  logic [KEY_OUT_W-1:0] out_key_r;
  hpq_status_t          out_st_r;
  logic [OCC_W-1:0]     out_occ_r;

  logic [IW-1:0]        left_w;
  logic [IW-1:0]        right_w;
  logic [IW-1:0]        cnt_x;
  logic [AW-1:0]        par_idx;
  logic                 right_ok;
  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  logic                 wr_en;
  logic [KEY_WIDTH-1:0] wr_data;
  logic [63:0]          key_wide;
  logic [63:0]          kout_wide;
  logic [31:0]          cnt_wide;
  logic                 out_load;

  // Heap index arithmetic around the hole position.
  assign left_w   = {1'b0, pos_r, 1'b1};
  assign right_w  = left_w + IW'(1);
  assign cnt_x    = IW'(cnt_r);
  assign par_idx  = (pos_r - AW'(1)) >> 1;
  assign right_ok = (right_w < cnt_x);

  // Width adaptation between the channel fields and the stored keys.
  assign key_wide  = 64'(in_key);
  assign kout_wide = 64'(kout_r);
  assign cnt_wide  = 32'(cnt_r);

  // Flags for the sequencer's jumps.
  assign flags.remove       = mode_r;
  assign flags.full         = (cnt_r == CW'(CAPACITY));
  assign flags.empty        = (cnt_r == '0);
  assign flags.pos_zero     = (pos_r == '0);
  assign flags.par_not_lt   = ~(hkey_r < rdat_r);
  assign flags.no_left      = (left_w >= cnt_x);
  assign flags.child_not_lt = ~(ckey_r < hkey_r);
  assign flags.out_busy     = out_valid_r & ~out_ready;

  // Memory read address selection.
  always_comb begin
    rd_en = 1'b1;
    case (uw.rd)
      RD_NONE: begin
        rd_en   = 1'b0;
        rd_addr = '0;
      end
      RD_ROOT:   rd_addr = '0;
      RD_PARENT: rd_addr = par_idx;
      RD_LEFT:   rd_addr = left_w[AW-1:0];
      RD_RIGHT:  rd_addr = right_w[AW-1:0];
      RD_LAST:   rd_addr = cnt_r[AW-1:0];
      default: begin
        rd_en   = 1'b0;
        rd_addr = '0;
      end
    endcase
  end

  // Memory write data selection; writes always land on the hole.
  always_comb begin
    wr_en = 1'b1;
    case (uw.wr)
      WR_NONE: begin
        wr_en   = 1'b0;
        wr_data = hkey_r;
      end
      WR_HKEY: wr_data = hkey_r;
      WR_RDAT: wr_data = rdat_r;
      WR_CKEY: wr_data = ckey_r;
      default: begin
        wr_en   = 1'b0;
        wr_data = hkey_r;
      end
    endcase
  end

  // Key memory with one write and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[pos_r] <= wr_data;
    end
    if (rd_en) begin
      rdat_r <= mem[rd_addr];
    end
  end

  // Working registers of the current operation.
  always_ff @(posedge clk) begin
    if (uw.in_ld && in_valid) begin
      mode_r <= in_mode;
      hkey_r <= key_wide[KEY_WIDTH-1:0];
    end else if (uw.hk_rdat) begin
      hkey_r <= rdat_r;
    end

    case (uw.pos)
      POS_CNT:    pos_r <= cnt_r[AW-1:0];
      POS_PARENT: pos_r <= par_idx;
      POS_CIDX:   pos_r <= cidx_r;
      POS_ZERO:   pos_r <= '0;
      default:    pos_r <= pos_r;
    endcase

    // Smaller child, the left one winning a tie.
    case (uw.ch)
      CH_LEFT: begin
        ckey_r <= rdat_r;
        cidx_r <= left_w[AW-1:0];
      end
      CH_RIGHT: begin
        if (right_ok && (rdat_r < ckey_r)) begin
          ckey_r <= rdat_r;
          cidx_r <= right_w[AW-1:0];
        end
      end
      default: begin
        ckey_r <= ckey_r;
      end
    endcase

    case (uw.ko)
      KO_CLEAR: kout_r <= '0;
      KO_RDAT:  kout_r <= rdat_r;
      default:  kout_r <= kout_r;
    endcase

    if (uw.st_ld) begin
      st_r <= uw.st;
    end
  end

  // Entry count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      case (uw.cnt)
        CNT_INC: cnt_r <= cnt_r + CW'(1);
        CNT_DEC: cnt_r <= cnt_r - CW'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  // Output register: holds a finished result until the sink takes the beat.
  assign out_load = uw.out_ld & ~flags.out_busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_key_r <= kout_wide[KEY_OUT_W-1:0];
      out_st_r  <= st_r;
      out_occ_r <= cnt_wide[OCC_W-1:0];
    end
  end

  assign out_valid     = out_valid_r;
  assign out_key_out   = out_key_r;
  assign out_status    = out_st_r;
  assign out_occupancy = out_occ_r;

endmodule

// ===== hdl/binary_min_heap_queue.sv =====
// Top level of the binary min-heap priority queue: sequencer plus datapath.
// Depends on hpq_pkg, hpq_chan_if, hpq_seq and hpq_dpath.
//
//   Channel   Direction  Beat contents
//   in_chan   sink       mode (0 insert, 1 remove), key
//   out_chan  source     key_out, status, occupancy
//
// One result per request. Each level of a sift costs one or two reads of
// the single-read-port key memory.
// Reset is synchronous and empties the queue; the key memory is not cleared.
// A finished result that finds the output register still occupied holds the
// sequencer until that beat is taken; no new request is accepted meanwhile.
module binary_min_heap_queue #(
  parameter int unsigned CAPACITY  = 1024,
  parameter int unsigned KEY_WIDTH = 32
) (
  input logic      clk,
  input logic      rst_n,
  hpq_in_if.sink   in_chan,
  hpq_out_if.source out_chan
);
  import hpq_pkg::*;

  hpq_uword_t uw;
  hpq_flags_t flags;

  // Microprogram sequencer.
  hpq_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .flags    (flags),
    .uw       (uw),
    .in_ready (in_chan.ready)
  );

  // Heap datapath and result register.
  hpq_dpath #(
    .CAPACITY  (CAPACITY),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .uw            (uw),
    .flags         (flags),
    .in_valid      (in_chan.valid),
    .in_mode       (in_chan.mode),
    .in_key        (in_chan.key),
    .out_valid     (out_chan.valid),
    .out_ready     (out_chan.ready),
    .out_key_out   (out_chan.key_out),
    .out_status    (out_chan.status),
    .out_occupancy (out_chan.occupancy)
  );

endmodule
